// ===== rtl/core/front_coded_table_name_search_macros.svh =====
// Assertion macros used by the checker file of the name search block.
// Depends on nothing; include by bare file name inside a module body.
`ifndef FRONT_CODED_TABLE_NAME_SEARCH_MACROS_SVH
`define FRONT_CODED_TABLE_NAME_SEARCH_MACROS_SVH

// Same-cycle implication, disabled during reset
`define FCTS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset
`define FCTS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/fcts_pkg.sv =====
// Package for the front-coded name table search: payload types, codes,
// controller/datapath interface structs and default sizes. No dependencies.
`timescale 1ns / 1ps

package fcts_pkg;

	// Default table geometry
	localparam int TABLE_ENTRIES_DEF = 64;
	localparam int NAME_LENGTH_DEF   = 32;

	// Item kind codes
	localparam logic [1:0] KIND_NAME  = 2'd0;
	localparam logic [1:0] KIND_ATTR  = 2'd1;
	localparam logic [1:0] KIND_QUERY = 2'd2;

	// Versions flagged in the result
	localparam logic [3:0] VERSION4 = 4'd4;
	localparam logic [3:0] VERSION5 = 4'd5;

	// Query terminator character
	localparam logic [7:0] CHAR_END = 8'd0;

	typedef struct packed {
		logic [1:0] kind;
		logic [5:0] entry;
		logic [4:0] position;
		logic [7:0] char_value;
		logic [4:0] shared_prefix;
		logic [3:0] entry_version;
	} req_t;

	typedef struct packed {
		logic       found;
		logic [5:0] match_index;
		logic       is_version4;
		logic       is_version5;
	} rsp_t;

	// Controller to datapath
	typedef struct packed {
		logic load_name;  // write name character
		logic load_attr;  // write prefix and version
		logic start;      // latch query character
		logic rd_cur;     // read at current entry and position
		logic rd_next;    // read at next entry, position zero
		logic adv_pos;    // advance matched length
		logic step_entry; // move to next entry
		logic set_fail;   // mark query failed
		logic push;       // load result register and clear query state
		logic found;      // result is a hit
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic lt;          // query char below table char
		logic eq;          // query char equals table char
		logic ch_zero;     // latched query char is the terminator
		logic over_prefix; // matched length beyond shared prefix
		logic last_entry;  // no entry after the current one
		logic name_empty;  // read character is zero
		logic failed;      // query already failed
	} sts_t;

endpackage

// ===== rtl/core/fcts_datapath.sv =====
// Datapath of the name search: name and attribute memories, query state
// registers, character compare and result register. Depends on fcts_pkg.
`timescale 1ns / 1ps

module fcts_datapath #(
	parameter int TABLE_ENTRIES = fcts_pkg::TABLE_ENTRIES_DEF,
	parameter int NAME_LENGTH   = fcts_pkg::NAME_LENGTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  fcts_pkg::req_t req,
	input  fcts_pkg::cmd_t cmd,
	output fcts_pkg::sts_t sts,
	output fcts_pkg::rsp_t rsp
);
	import fcts_pkg::*;

	localparam int EW  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int PW  = (NAME_LENGTH > 1) ? $clog2(NAME_LENGTH) : 1;
	localparam int PCW = $clog2(NAME_LENGTH + 1);
	localparam int CW  = (PCW > 5) ? PCW : 5;
	localparam int NAME_DEPTH = 2 ** (EW + PW);
	localparam int ATTR_DEPTH = 2 ** EW;

	logic [7:0] name_mem [NAME_DEPTH];
	logic [8:0] attr_mem [ATTR_DEPTH];

	logic [EW:0]    entry_q;
	logic [PCW-1:0] pos_q;
	logic           failed_q;
	logic [7:0]     ch_q;
	logic [7:0]     name_rd_q;
	logic           over_q;
	logic [4:0]     prefix_rd_q;
	logic [3:0]     ver_rd_q;
	rsp_t           rsp_q;

	logic [EW:0]       next_entry;
	logic [EW-1:0]     rd_entry;
	logic [PW-1:0]     rd_pos;
	logic [EW+PW-1:0]  rd_addr;
	logic [EW+PW-1:0]  wr_addr;
	logic              rd_en;
	logic              name_wr_ok;
	logic              attr_wr_ok;
	logic [7:0]        table_ch;

	// Read address: current entry and position, or start of the next entry
	assign next_entry = entry_q + 1'b1;
	assign rd_entry   = cmd.rd_next ? next_entry[EW-1:0] : entry_q[EW-1:0];
	assign rd_pos     = cmd.rd_next ? '0 : pos_q[PW-1:0];
	assign rd_addr    = {rd_entry, rd_pos};
	assign rd_en      = cmd.rd_cur | cmd.rd_next;

	// Drop loads outside the table
	assign wr_addr    = {EW'(req.entry), PW'(req.position)};
	assign name_wr_ok = (32'(req.entry) < TABLE_ENTRIES) && (32'(req.position) < NAME_LENGTH);
	assign attr_wr_ok = 32'(req.entry) < TABLE_ENTRIES;

	// Name memory, one write and one registered read port
	always_ff @(posedge clk) begin
		if (cmd.load_name && name_wr_ok) begin
			name_mem[wr_addr] <= req.char_value;
		end
		if (rd_en) begin
			name_rd_q <= name_mem[rd_addr];
		end
	end

	// Prefix and version memory, read at the same entry as the name
	always_ff @(posedge clk) begin
		if (cmd.load_attr && attr_wr_ok) begin
			attr_mem[EW'(req.entry)] <= {req.shared_prefix, req.entry_version};
		end
		if (rd_en) begin
			{prefix_rd_q, ver_rd_q} <= attr_mem[rd_entry];
		end
	end

	// Position past the name end reads as zero
	always_ff @(posedge clk) begin
		if (rd_en) begin
			over_q <= cmd.rd_cur && (32'(pos_q) == NAME_LENGTH);
		end
		if (cmd.start) begin
			ch_q <= req.char_value;
		end
	end

	// Query state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q  <= '0;
			pos_q    <= '0;
			failed_q <= 1'b0;
		end else if (cmd.push) begin
			entry_q  <= '0;
			pos_q    <= '0;
			failed_q <= 1'b0;
		end else begin
			if (cmd.step_entry) begin
				entry_q <= next_entry;
			end
			if (cmd.adv_pos && (32'(pos_q) < NAME_LENGTH)) begin
				pos_q <= pos_q + 1'b1;
			end
			if (cmd.set_fail) begin
				failed_q <= 1'b1;
			end
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (cmd.push) begin
			rsp_q.found       <= cmd.found;
			rsp_q.match_index <= cmd.found ? 6'(entry_q) : 6'd0;
			rsp_q.is_version4 <= cmd.found && (ver_rd_q == VERSION4);
			rsp_q.is_version5 <= cmd.found && (ver_rd_q == VERSION5);
		end
	end

	// Compare status
	assign table_ch        = over_q ? CHAR_END : name_rd_q;
	assign sts.lt          = ch_q < table_ch;
	assign sts.eq          = ch_q == table_ch;
	assign sts.ch_zero     = ch_q == CHAR_END;
	assign sts.over_prefix = CW'(pos_q) > CW'(prefix_rd_q);
	assign sts.last_entry  = entry_q >= (EW + 1)'(TABLE_ENTRIES - 1);
	assign sts.name_empty  = name_rd_q == CHAR_END;
	assign sts.failed      = failed_q;

	assign rsp = rsp_q;

endmodule

// ===== rtl/core/fcts_ctrl.sv =====
// Controller of the name search: sequences compares and entry skips per
// query character and owns both handshakes. Depends on fcts_pkg.
`timescale 1ns / 1ps

module fcts_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  fcts_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	input  fcts_pkg::sts_t sts,
	output fcts_pkg::cmd_t cmd
);
	import fcts_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_COMP  = 4'b0010,
		ST_CHECK = 4'b0100,
		ST_PUSH  = 4'b1000
	} state_t;

	state_t state_q, state_d;
	logic   found_q, found_d;
	logic   rsp_valid_q;
	logic   space;
	logic   fin_hit;
	logic   fin_fail;
	logic   term;

	assign space     = !rsp_valid_q || rsp_ready;
	assign req_ready = state_q == ST_IDLE;
	assign rsp_valid = rsp_valid_q;

	// Next state and commands
	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		found_d  = found_q;
		fin_hit  = 1'b0;
		fin_fail = 1'b0;
		term     = sts.ch_zero;
		unique case (state_q)
			ST_IDLE: begin
				term = req.char_value == CHAR_END;
				if (req_valid) begin
					priority if (req.kind == KIND_NAME) begin
						cmd.load_name = 1'b1;
					end else if (req.kind == KIND_ATTR) begin
						cmd.load_attr = 1'b1;
					end else if (req.kind == KIND_QUERY) begin
						if (sts.failed) begin
							fin_fail = 1'b1;
						end else begin
							cmd.start  = 1'b1;
							cmd.rd_cur = 1'b1;
							state_d    = ST_COMP;
						end
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_COMP: begin
				priority if (sts.lt) begin
					fin_fail = 1'b1;
				end else if (sts.eq) begin
					if (sts.ch_zero) begin
						fin_hit = 1'b1;
					end else begin
						cmd.adv_pos = 1'b1;
						state_d     = ST_IDLE;
					end
				end else if (sts.over_prefix || sts.last_entry) begin
					fin_fail = 1'b1;
				end else begin
					cmd.step_entry = 1'b1;
					cmd.rd_next    = 1'b1;
					state_d        = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (sts.name_empty) begin
					fin_fail = 1'b1;
				end else begin
					cmd.rd_cur = 1'b1;
					state_d    = ST_COMP;
				end
			end
			ST_PUSH: begin
				if (space) begin
					cmd.push  = 1'b1;
					cmd.found = found_q;
					state_d   = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase

		// Finish the character: report on the terminator, else mark failure
		if (fin_hit || (fin_fail && term)) begin
			if (space) begin
				cmd.push  = 1'b1;
				cmd.found = fin_hit;
				state_d   = ST_IDLE;
			end else begin
				found_d = fin_hit;
				state_d = ST_PUSH;
			end
		end else if (fin_fail) begin
			cmd.set_fail = 1'b1;
			state_d      = ST_IDLE;
		end
	end

	// State and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			found_q     <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			found_q <= found_d;
			if (cmd.push) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== rtl/core/front_coded_table_name_search.sv =====
// Top level of the front-coded sorted name table search.
// Joins fcts_ctrl and fcts_datapath; depends on fcts_pkg.
//
// Usage: one valid/ready input channel (req) carries name character loads,
// entry prefix/version loads and query characters; one valid/ready output
// channel (rsp) carries one result per query terminator (character 0).
// A load is written as it is accepted. A query character is accepted,
// then compared against the name memory; for every table entry
// skipped, the block reads the next entry's first character, then the
// character at the matched position, one name memory read per cycle. A
// character arriving after the query failed is not compared.
// The result is registered once the output has space. Input is taken
// while a result waits; only a further result stalls the block until
// the receiver takes the pending one.
// Reset clears the query state (entry, matched length, failure) and the
// output valid; table contents are undefined until loaded.
`timescale 1ns / 1ps

module front_coded_table_name_search #(
	parameter int TABLE_ENTRIES = fcts_pkg::TABLE_ENTRIES_DEF,
	parameter int NAME_LENGTH   = fcts_pkg::NAME_LENGTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  fcts_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output fcts_pkg::rsp_t rsp
);
	import fcts_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// Sequence each transaction
	fcts_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Hold the table and query state
	fcts_datapath #(
		.TABLE_ENTRIES (TABLE_ENTRIES),
		.NAME_LENGTH   (NAME_LENGTH)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.sts    (sts),
		.rsp    (rsp)
	);

endmodule

// ===== rtl/core/fcts_checker.sv =====
// Port-level checker for the name search top level, bound to it below.
// Depends on fcts_pkg and front_coded_table_name_search_macros.svh.
`timescale 1ns / 1ps

module fcts_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           req_valid,
	input logic           req_ready,
	input fcts_pkg::req_t req,
	input logic           rsp_valid,
	input logic           rsp_ready,
	input fcts_pkg::rsp_t rsp
);
	import fcts_pkg::*;
	`include "front_coded_table_name_search_macros.svh"

	// Loads never produce a result
	`FCTS_ASSERT_NEXT(a_load_no_rsp, clk, arst_n, req_valid && req_ready && !rsp_valid && (req.kind == KIND_NAME || req.kind == KIND_ATTR), !rsp_valid, "result after a load transaction")

	// A non-terminating query character produces no result in the next cycle
	`FCTS_ASSERT_NEXT(a_char_no_rsp, clk, arst_n, req_valid && req_ready && !rsp_valid && req.kind == KIND_QUERY && req.char_value != CHAR_END, !rsp_valid, "result after a non-terminating character")

	// A miss reports zero index and no version flags
	`FCTS_ASSERT_NOW(a_miss_clean, clk, arst_n, rsp_valid && !rsp.found, rsp.match_index == 6'd0 && !rsp.is_version4 && !rsp.is_version5, "miss result carries index or version")

	// Hold a stalled result
	`FCTS_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp), "stalled result changed")

endmodule

bind front_coded_table_name_search fcts_checker u_fcts_checker (.*);
